// ----- rtl/core/rlbs_pkg.sv -----
// ----------------------------------------------------------------------------
// rlbs_pkg
// Shared types and constants for the rightmost-at-most binary search unit.
// ----------------------------------------------------------------------------
package rlbs_pkg;

  localparam int DEPTH_DEF  = 1024;
  localparam int ELEM_W     = 32;
  localparam int POS_W      = 10;
  localparam int ACT_W      = 2;
  localparam int QDEPTH_DEF = 2;

  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_APPEND = 2'd1;
  localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd2;
  localparam logic [ACT_W-1:0] ACT_RSVD   = 2'd3;

  typedef struct packed {
    logic [ACT_W-1:0]         action;
    logic signed [ELEM_W-1:0] element;
    logic signed [ELEM_W-1:0] target;
  } in_item_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } out_item_t;

  // Classified command handed from the front to the back.
  typedef struct packed {
    logic [ACT_W-1:0]         op;
    logic signed [ELEM_W-1:0] data;
  } cmd_t;

  // Queue head as seen by the back.
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

endpackage

// ----- rtl/core/rlbs_front.sv -----
// ----------------------------------------------------------------------------
// rlbs_front
// Input side: takes items, drops reserved actions and packs the operand
// that the action needs into one command word for the queue.
// ----------------------------------------------------------------------------
module rlbs_front
  import rlbs_pkg::*;
(
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  input  logic     q_full,
  output logic     q_push,
  output cmd_t     q_cmd
);

  logic keep;

  always_comb begin
    keep       = 1'b1;
    q_cmd.op   = in_data.action;
    q_cmd.data = in_data.target;
    unique case (in_data.action)
      ACT_CLEAR:  q_cmd.data = '0;
      ACT_APPEND: q_cmd.data = in_data.element;
      ACT_SEARCH: q_cmd.data = in_data.target;
      default:    keep       = 1'b0;  // drop reserved action
    endcase
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && keep;

endmodule

// ----- rtl/core/rlbs_queue.sv -----
// ----------------------------------------------------------------------------
// rlbs_queue
// Small command queue between the front and the back.
// ----------------------------------------------------------------------------
module rlbs_queue
  import rlbs_pkg::*;
#(
  parameter int QDEPTH = QDEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  cmd_t    push_cmd,
  output logic    full,
  input  logic    pop,
  output q_head_t head
);

  localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCW = $clog2(QDEPTH + 1);

  cmd_t           slot_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r;
  logic [QAW-1:0] rd_ptr_r;
  logic [QCW-1:0] cnt_r;
  logic           do_push;
  logic           do_pop;

  assign full      = (cnt_r == QCW'(QDEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.cmd   = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && head.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_r + QAW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_r + QAW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + QCW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - QCW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ----- rtl/core/rlbs_back.sv -----
// ----------------------------------------------------------------------------
// rlbs_back
// Execution side: element memory, fill count, search sequencer and the
// result register.
// ----------------------------------------------------------------------------
module rlbs_back
  import rlbs_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  q_head_t   head,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [ELEM_W-1:0]        mem [DEPTH];
  logic [ELEM_W-1:0]        rd_data_r;

  logic [1:0]               state_r;
  logic [CW-1:0]            count_r;
  logic [CW-1:0]            lo_r;
  logic [CW-1:0]            hi_r;   // one past the last candidate
  logic [CW-1:0]            mid_r;
  logic [CW-1:0]            pos_r;
  logic                     hit_r;
  logic signed [ELEM_W-1:0] tgt_r;
  logic                     out_valid_r;
  out_item_t                out_data_r;

  logic [CW-1:0]            lo_nxt;
  logic [CW-1:0]            hi_nxt;
  logic [CW-1:0]            pos_nxt;
  logic                     hit_nxt;
  logic [CW-1:0]            span;
  logic [CW-1:0]            mid_nxt;
  logic                     more;
  logic                     le;
  logic                     start;
  logic                     probe;
  logic                     wr_en;
  logic                     out_free;
  logic                     load_out;

  assign out_free = !out_valid_r || !out_stall;
  assign load_out = (state_r == S_DONE) && out_free;
  assign pop      = (state_r == S_IDLE) && head.valid;
  assign start    = pop && (head.cmd.op == ACT_SEARCH);
  assign wr_en    = pop && (head.cmd.op == ACT_APPEND) && (count_r < CW'(DEPTH));
  assign le       = $signed(rd_data_r) <= tgt_r;

  // Narrow the window from the probed element, then pick the next probe.
  always_comb begin
    lo_nxt  = lo_r;
    hi_nxt  = hi_r;
    hit_nxt = hit_r;
    pos_nxt = pos_r;
    if (state_r == S_IDLE) begin
      lo_nxt  = '0;
      hi_nxt  = count_r;
      hit_nxt = 1'b0;
      pos_nxt = '0;
    end else if (state_r == S_CMP) begin
      if (le) begin
        hit_nxt = 1'b1;
        pos_nxt = mid_r;
        lo_nxt  = mid_r + CW'(1);
      end else begin
        hi_nxt  = mid_r;
      end
    end
    more    = lo_nxt < hi_nxt;
    span    = hi_nxt - lo_nxt - CW'(1);
    mid_nxt = lo_nxt + (span >> 1);
  end

  assign probe = more && (start || (state_r == S_CMP));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[AW-1:0]] <= head.cmd.data;
    end
    if (probe) begin
      rd_data_r <= mem[mid_nxt[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (pop) begin
            case (head.cmd.op)
              ACT_CLEAR:  count_r <= '0;
              ACT_APPEND: if (wr_en) count_r <= count_r + CW'(1);
              ACT_SEARCH: state_r <= more ? S_CMP : S_DONE;
              default:    count_r <= count_r;
            endcase
          end
        end
        S_CMP: begin
          if (!more) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      tgt_r <= head.cmd.data;
    end
    if (start || (state_r == S_CMP)) begin
      lo_r  <= lo_nxt;
      hi_r  <= hi_nxt;
      hit_r <= hit_nxt;
      pos_r <= pos_nxt;
      mid_r <= mid_nxt;
    end
    if (load_out) begin
      out_data_r.found    <= hit_r;
      out_data_r.position <= hit_r ? POS_W'(pos_r) : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/core/rightmost_le_binary_search_unit.sv -----
// ----------------------------------------------------------------------------
// rightmost_le_binary_search_unit
// Store of ascending signed words with a rightmost-at-most binary search.
// ----------------------------------------------------------------------------
// Usage:
//   in_* carries one item per transfer: clear the store, append one
//   element, or search for the rightmost position whose element is at most
//   the target. Reserved action codes are taken and dropped.
//   out_* carries one result per search (found, position); clear and
//   append give no result. Appends to a full store are dropped.
// Search sequencing:
//   Clear and append are executed by the back end when it is idle. A
//   search narrows the candidate window with one memory probe per cycle
//   through the element memory's single read port; a search of an empty
//   store makes no probe. The result is then registered onto out_*.
//   A two-entry command queue lets input transfers proceed while a search
//   runs; in_stall rises when it is full.
// Reset and stall:
//   Reset empties the store and the queue and drops any pending result;
//   memory contents are not cleared. While out_stall is high a pending
//   result holds, and a finished search waits before the next command.
// ----------------------------------------------------------------------------
module rightmost_le_binary_search_unit
  import rlbs_pkg::*;
#(
  parameter int DEPTH  = DEPTH_DEF,
  parameter int QDEPTH = QDEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic    q_full;
  logic    q_push;
  cmd_t    q_cmd;
  logic    q_pop;
  q_head_t q_head;

  rlbs_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  rlbs_queue #(
    .QDEPTH (QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head)
  );

  rlbs_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/core/rlbs_checker.sv -----
// ----------------------------------------------------------------------------
// rlbs_checker
// Port-level checks for the binary search unit, bound to the top level.
// ----------------------------------------------------------------------------
module rlbs_checker
  import rlbs_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result changed while stalled");

  // A miss always reports position zero.
  a_miss_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |-> out_data.position == '0)
    else $error("miss with nonzero position");

  // Reset drops any pending result and leaves the input unstalled.
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_rst_in: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled after reset");

endmodule

bind rightmost_le_binary_search_unit rlbs_checker u_chk (.*);
